// ===== rtl/core/shs_pkg.sv =====
// Shared types and codes for the session handshake state machine.
package shs_pkg;

  // Event kinds carried in the command field.
  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_TIMER  = 2'd1;
  localparam logic [1:0] CMD_ERROR  = 2'd2;
  localparam logic [1:0] CMD_START  = 2'd3;

  // Message types, shared by msg_type and send_msg.
  localparam logic [3:0] MSG_LOGIN     = 4'd0;
  localparam logic [3:0] MSG_CHALLENGE = 4'd1;
  localparam logic [3:0] MSG_RESPONSE  = 4'd2;
  localparam logic [3:0] MSG_AUTH_OK   = 4'd3;
  localparam logic [3:0] MSG_DENY      = 4'd4;
  localparam logic [3:0] MSG_IPCONF    = 4'd5;
  localparam logic [3:0] MSG_KA        = 4'd6;
  localparam logic [3:0] MSG_DATA      = 4'd7;
  localparam logic [3:0] MSG_RST       = 4'd8;

  // Session state codes as reported on session_state.
  localparam logic [2:0] CODE_LOGIN_SENT    = 3'd0;
  localparam logic [2:0] CODE_RESPONSE_SENT = 3'd1;
  localparam logic [2:0] CODE_CLIENT_CONN   = 3'd2;
  localparam logic [2:0] CODE_IDLE          = 3'd3;
  localparam logic [2:0] CODE_LISTEN        = 3'd4;
  localparam logic [2:0] CODE_CHAL_SENT     = 3'd5;
  localparam logic [2:0] CODE_STALE         = 3'd6;
  localparam logic [2:0] CODE_SERVER_CONN   = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_SERVER_ROLE     = 2'd0;
  localparam logic [1:0] REG_HANDSHAKE_TICKS = 2'd1;
  localparam logic [1:0] REG_KEEPALIVE_TICKS = 2'd2;
  localparam logic [1:0] REG_MAX_RETRIES     = 2'd3;

  localparam logic [4:0] RETRY_MAX = 5'd31;

  typedef enum logic [7:0] {
    ST_LOGIN_SENT    = 8'b0000_0001,
    ST_RESPONSE_SENT = 8'b0000_0010,
    ST_CLIENT_CONN   = 8'b0000_0100,
    ST_IDLE          = 8'b0000_1000,
    ST_LISTEN        = 8'b0001_0000,
    ST_CHAL_SENT     = 8'b0010_0000,
    ST_STALE         = 8'b0100_0000,
    ST_SERVER_CONN   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] msg_type;
    logic       addr_ok;
    logic       crypt_ok;
    logic       send_ok;
    logic       challenge_match;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  session_state;
    logic        send_valid;
    logic [3:0]  send_msg;
    logic        timer_arm;
    logic [31:0] timer_interval;
    logic        timer_cancel;
    logic        session_closed;
  } out_item_t;

  typedef struct packed {
    logic        server_role;
    logic [15:0] handshake_ticks;
    logic [31:0] keepalive_ticks;
    logic [3:0]  max_retries;
  } cfg_t;

  typedef struct packed {
    state_e     next_state;
    logic [4:0] next_retry;
    out_item_t  result;
  } step_t;

endpackage

// ===== rtl/core/session_handshake_fsm.sv =====
// Session handshake state machine top level: event register, decode, result register.
//
// One tunnel session's login/challenge/keepalive controller for the client or
// server role. Each input beat is one event (packet, timer expiry, socket error,
// start) and produces exactly one output beat carrying the new session state,
// the message to send if any, and the timer arm/cancel request. The block takes
// one event per cycle while the result side is not stalled: an event lands in
// the input register, the decode reads it together with the session state and
// retry count, and on the same edge the result register loads and the state
// advances, so the next event sees the updated state. An event reaches the
// output by way of the input register, the decode and the result register.
// Throughput is set only by the result register draining: input ready stays
// high while the input register is empty or its event advances this cycle, so
// it drops only when both registers hold a beat and the output is stalled.
// Configuration writes are taken every cycle and must only be issued while no
// event is in flight.
module session_handshake_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  // event channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  shs_pkg::in_item_t   in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output shs_pkg::out_item_t  out_data_o,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import shs_pkg::*;

  cfg_t      cfg;
  step_t     step;

  logic      in_valid_q, in_valid_d;
  in_item_t  in_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q;
  state_e    state_q, state_d;
  logic [4:0] retry_q, retry_d;

  logic      advance;
  logic      in_accept;

  shs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  shs_step u_step (
    .state_i (state_q),
    .retry_i (retry_q),
    .item_i  (in_q),
    .cfg_i   (cfg),
    .step_o  (step)
  );

  // Advance the held event when the result register is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    retry_d     = retry_q;
    if (advance) begin
      in_valid_d = 1'b0;
      state_d    = step.next_state;
      retry_d    = step.next_retry;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
    // drop the shown result once taken, replace it when a new one is decoded
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_IDLE;
      retry_q     <= 5'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      retry_q     <= retry_d;
    end
  end

  // Payload registers: hold unless a new beat is loaded.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= step.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/shs_cfg.sv =====
// Configuration register file for the session handshake state machine.
module shs_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i,
  output shs_pkg::cfg_t    cfg_o
);
  import shs_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SERVER_ROLE:     cfg_d.server_role     = cfg_data_i[0];
        REG_HANDSHAKE_TICKS: cfg_d.handshake_ticks = cfg_data_i[15:0];
        REG_KEEPALIVE_TICKS: cfg_d.keepalive_ticks = cfg_data_i;
        REG_MAX_RETRIES:     cfg_d.max_retries     = cfg_data_i[3:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.server_role     <= 1'b0;
      cfg_q.handshake_ticks <= 16'd1000;
      cfg_q.keepalive_ticks <= 32'd10000;
      cfg_q.max_retries     <= 4'd5;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/shs_step.sv =====
// Next-state and result decode for one event of the session handshake.
module shs_step (
  input  shs_pkg::state_e   state_i,
  input  logic [4:0]        retry_i,
  input  shs_pkg::in_item_t item_i,
  input  shs_pkg::cfg_t     cfg_i,
  output shs_pkg::step_t    step_o
);
  import shs_pkg::*;

  state_e      ns;
  logic [4:0]  nr;
  logic [4:0]  bumped;
  logic        sv;
  logic [3:0]  msg;
  logic        arm;
  logic        cancel;
  logic        closed;
  logic [47:0] shifted;
  logic [31:0] hs_interval;
  logic [31:0] interval;
  logic [2:0]  code;

  assign bumped = (retry_i == RETRY_MAX) ? RETRY_MAX : retry_i + 5'd1;

  always_comb begin
    ns     = state_i;
    nr     = retry_i;
    sv     = 1'b0;
    msg    = MSG_LOGIN;
    arm    = 1'b0;
    cancel = 1'b0;
    closed = 1'b0;
    unique case (item_i.command)
      CMD_PACKET: begin
        priority if (item_i.msg_type > MSG_RST ||
                     (state_i != ST_LISTEN && !item_i.addr_ok)) begin
          ns = state_i;
        end else if (state_i == ST_LISTEN && item_i.msg_type == MSG_LOGIN) begin
          cancel = 1'b1;
          nr     = 5'd0;
          ns     = ST_STALE;
          if (item_i.crypt_ok && item_i.send_ok) begin
            sv  = 1'b1;
            msg = MSG_CHALLENGE;
            ns  = ST_CHAL_SENT;
          end
          arm = 1'b1;
        end else if (state_i == ST_LOGIN_SENT && item_i.msg_type == MSG_CHALLENGE) begin
          cancel = 1'b1;
          if (item_i.crypt_ok) begin
            sv  = item_i.send_ok;
            msg = item_i.send_ok ? MSG_RESPONSE : MSG_LOGIN;
            ns  = item_i.send_ok ? ST_RESPONSE_SENT : ST_IDLE;
          end
          arm = 1'b1;
        end else if (state_i == ST_CHAL_SENT && item_i.msg_type == MSG_RESPONSE) begin
          cancel = 1'b1;
          if (item_i.challenge_match) begin
            sv  = item_i.send_ok;
            msg = item_i.send_ok ? MSG_AUTH_OK : MSG_LOGIN;
            ns  = item_i.send_ok ? ST_SERVER_CONN : ST_STALE;
          end
          arm = 1'b1;
        end else if ((state_i == ST_CHAL_SENT || state_i == ST_STALE) &&
                     item_i.msg_type == MSG_RST) begin
          cancel = 1'b1;
          ns     = ST_STALE;
          arm    = 1'b1;
        end else if (state_i == ST_RESPONSE_SENT && item_i.msg_type == MSG_AUTH_OK) begin
          cancel = 1'b1;
          nr     = 5'd0;
          ns     = ST_CLIENT_CONN;
          arm    = 1'b1;
        end else if (state_i == ST_RESPONSE_SENT && item_i.msg_type == MSG_DENY) begin
          cancel = 1'b1;
          nr     = 5'd0;
          sv     = item_i.send_ok;
          ns     = item_i.send_ok ? ST_LOGIN_SENT : ST_IDLE;
          arm    = 1'b1;
        end else if ((state_i == ST_CLIENT_CONN || state_i == ST_SERVER_CONN) &&
                     item_i.msg_type == MSG_KA) begin
          cancel = 1'b1;
          nr     = 5'd0;
        end else if ((state_i == ST_CLIENT_CONN &&
                      (item_i.msg_type == MSG_IPCONF || item_i.msg_type == MSG_DATA)) ||
                     (state_i == ST_SERVER_CONN && item_i.msg_type == MSG_DATA)) begin
          cancel = 1'b1;
        end else begin
          ns = state_i;
        end
      end
      CMD_TIMER: begin
        priority if (state_i == ST_LOGIN_SENT || state_i == ST_RESPONSE_SENT ||
                     state_i == ST_CLIENT_CONN || state_i == ST_IDLE) begin
          nr = bumped;
          if (bumped > {1'b0, cfg_i.max_retries}) begin
            nr = 5'd0;
            sv = item_i.send_ok;
            ns = item_i.send_ok ? ST_LOGIN_SENT : ST_IDLE;
          end else if (state_i == ST_IDLE || state_i == ST_LOGIN_SENT) begin
            sv = item_i.send_ok;
            ns = item_i.send_ok ? ST_LOGIN_SENT : ST_IDLE;
          end else if (state_i == ST_CLIENT_CONN) begin
            sv  = item_i.send_ok;
            msg = item_i.send_ok ? MSG_KA : MSG_LOGIN;
          end
          arm = 1'b1;
        end else if (state_i == ST_STALE) begin
          ns     = ST_LISTEN;
          nr     = 5'd0;
          closed = 1'b1;
        end else begin
          nr = bumped;
          if (bumped > {1'b0, cfg_i.max_retries}) begin
            ns = ST_STALE;
          end else if (state_i == ST_SERVER_CONN) begin
            sv  = item_i.send_ok;
            msg = item_i.send_ok ? MSG_KA : MSG_LOGIN;
          end
          arm = 1'b1;
        end
      end
      CMD_ERROR: begin
        ns = cfg_i.server_role ? ST_STALE : ST_IDLE;
      end
      CMD_START: begin
        nr = 5'd0;
        if (cfg_i.server_role) begin
          ns = ST_LISTEN;
        end else begin
          sv  = item_i.send_ok;
          ns  = item_i.send_ok ? ST_LOGIN_SENT : ST_IDLE;
          arm = item_i.send_ok;
        end
      end
      default: begin
        ns = state_i;
      end
    endcase
  end

  // Handshake interval: base ticks shifted by the updated retry count, saturated.
  assign shifted     = {32'd0, cfg_i.handshake_ticks} << nr;
  assign hs_interval = (|shifted[47:32]) ? 32'hFFFF_FFFF : shifted[31:0];
  assign interval    = !arm ? 32'd0 :
                       (ns == ST_CLIENT_CONN || ns == ST_SERVER_CONN) ?
                       cfg_i.keepalive_ticks : hs_interval;

  always_comb begin
    unique case (ns)
      ST_LOGIN_SENT:    code = CODE_LOGIN_SENT;
      ST_RESPONSE_SENT: code = CODE_RESPONSE_SENT;
      ST_CLIENT_CONN:   code = CODE_CLIENT_CONN;
      ST_IDLE:          code = CODE_IDLE;
      ST_LISTEN:        code = CODE_LISTEN;
      ST_CHAL_SENT:     code = CODE_CHAL_SENT;
      ST_STALE:         code = CODE_STALE;
      ST_SERVER_CONN:   code = CODE_SERVER_CONN;
      default:          code = CODE_IDLE;
    endcase
  end

  always_comb begin
    step_o.next_state            = ns;
    step_o.next_retry            = nr;
    step_o.result.session_state  = code;
    step_o.result.send_valid     = sv;
    step_o.result.send_msg       = sv ? msg : MSG_LOGIN;
    step_o.result.timer_arm      = arm;
    step_o.result.timer_interval = interval;
    step_o.result.timer_cancel   = cancel;
    step_o.result.session_closed = closed;
  end

endmodule

// ===== rtl/core/shs_checker.sv =====
// Port-level checker for the session handshake state machine, with its bind.
module shs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input shs_pkg::out_item_t out_data_o
);
  import shs_pkg::*;

  // A shown result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // Input stalls only behind a full result register.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with room at the output");

  // No message type without a send, no interval without an arm.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.send_valid || out_data_o.send_msg == MSG_LOGIN) &&
                    (out_data_o.timer_arm || out_data_o.timer_interval == 32'd0))
    else $error("send or timer field set without its strobe");

  // A freed session is back in listen with nothing sent or armed.
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.session_closed |->
      out_data_o.session_state == CODE_LISTEN &&
      !out_data_o.timer_arm && !out_data_o.send_valid)
    else $error("session close with wrong state or side effects");

endmodule

bind session_handshake_fsm shs_checker u_shs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== tb/session_checker.sv =====
// Checker that predicts and scores every result beat of the session handshake state machine.
module session_checker
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          events_o,
  output int          results_o
);

  localparam int MAX_REPORTS = 10;

  // Shadow copy of the registers and of the session.
  logic        role_server = 1'b0;
  logic [15:0] hs_ticks    = 16'd1000;
  logic [31:0] ka_ticks    = 32'd10000;
  logic [3:0]  retry_limit = 4'd5;
  logic [2:0]  sess_state  = CODE_IDLE;
  logic [4:0]  retries     = '0;

  out_item_t   expected_q[$];
  out_item_t   want;

  // Apply one event to the shadow session and return the result beat it must produce.
  function automatic out_item_t advance_session(in_item_t ev);
    out_item_t   r;
    logic [2:0]  cur;
    logic        tx_try;
    logic [3:0]  tx_msg;
    logic        arm;
    logic [63:0] span;
    r      = '0;
    cur    = sess_state;
    tx_try = 1'b0;
    tx_msg = MSG_LOGIN;
    arm    = 1'b0;
    case (ev.command)
      CMD_PACKET: begin
        // listen takes a login from any source
        if (ev.msg_type <= MSG_RST && (cur == CODE_LISTEN || ev.addr_ok)) begin
          if (cur == CODE_LISTEN && ev.msg_type == MSG_LOGIN) begin
            retries    = '0;
            sess_state = CODE_STALE;
            if (ev.crypt_ok) begin
              tx_try = 1'b1;
              tx_msg = MSG_CHALLENGE;
              if (ev.send_ok) sess_state = CODE_CHAL_SENT;
            end
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if (cur == CODE_LOGIN_SENT && ev.msg_type == MSG_CHALLENGE) begin
            if (ev.crypt_ok) begin
              tx_try     = 1'b1;
              tx_msg     = MSG_RESPONSE;
              sess_state = ev.send_ok ? CODE_RESPONSE_SENT : CODE_IDLE;
            end
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if (cur == CODE_CHAL_SENT && ev.msg_type == MSG_RESPONSE) begin
            if (ev.challenge_match) begin
              tx_try     = 1'b1;
              tx_msg     = MSG_AUTH_OK;
              sess_state = ev.send_ok ? CODE_SERVER_CONN : CODE_STALE;
            end
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if ((cur == CODE_CHAL_SENT || cur == CODE_STALE) && ev.msg_type == MSG_RST) begin
            sess_state     = CODE_STALE;
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if (cur == CODE_RESPONSE_SENT && ev.msg_type == MSG_AUTH_OK) begin
            retries        = '0;
            sess_state     = CODE_CLIENT_CONN;
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if (cur == CODE_RESPONSE_SENT && ev.msg_type == MSG_DENY) begin
            retries        = '0;
            tx_try         = 1'b1;
            tx_msg         = MSG_LOGIN;
            sess_state     = ev.send_ok ? CODE_LOGIN_SENT : CODE_IDLE;
            r.timer_cancel = 1'b1;
            arm            = 1'b1;
          end else if ((cur == CODE_CLIENT_CONN || cur == CODE_SERVER_CONN) &&
                       ev.msg_type == MSG_KA) begin
            retries        = '0;
            r.timer_cancel = 1'b1;
          end else if ((cur == CODE_CLIENT_CONN &&
                        (ev.msg_type == MSG_IPCONF || ev.msg_type == MSG_DATA)) ||
                       (cur == CODE_SERVER_CONN && ev.msg_type == MSG_DATA)) begin
            r.timer_cancel = 1'b1;
          end
        end
      end
      CMD_TIMER: begin
        if (cur == CODE_STALE) begin
          sess_state       = CODE_LISTEN;
          retries          = '0;
          r.session_closed = 1'b1;
        end else begin
          if (retries != RETRY_MAX) retries = retries + 5'd1;
          arm = 1'b1;
          if (cur <= CODE_IDLE) begin
            if (retries > retry_limit || cur == CODE_IDLE || cur == CODE_LOGIN_SENT) begin
              if (retries > retry_limit) retries = '0;
              tx_try     = 1'b1;
              tx_msg     = MSG_LOGIN;
              sess_state = ev.send_ok ? CODE_LOGIN_SENT : CODE_IDLE;
            end else if (cur == CODE_CLIENT_CONN) begin
              tx_try = 1'b1;
              tx_msg = MSG_KA;
            end
          end else begin
            if (retries > retry_limit) sess_state = CODE_STALE;
            if (sess_state == CODE_SERVER_CONN) begin
              tx_try = 1'b1;
              tx_msg = MSG_KA;
            end
          end
        end
      end
      CMD_ERROR: begin
        sess_state = role_server ? CODE_STALE : CODE_IDLE;
      end
      CMD_START: begin
        retries = '0;
        if (role_server) begin
          sess_state = CODE_LISTEN;
        end else begin
          tx_try     = 1'b1;
          tx_msg     = MSG_LOGIN;
          sess_state = ev.send_ok ? CODE_LOGIN_SENT : CODE_IDLE;
          arm        = ev.send_ok;
        end
      end
    endcase
    if (tx_try && ev.send_ok) begin
      r.send_valid = 1'b1;
      r.send_msg   = tx_msg;
    end
    // interval follows the state after the step; saturate past 32 bits
    if (arm) begin
      span = {48'd0, hs_ticks} << retries;
      if (span[63:32] != '0) span = {32'd0, 32'hFFFF_FFFF};
      if (sess_state == CODE_CLIENT_CONN || sess_state == CODE_SERVER_CONN)
        span = {32'd0, ka_ticks};
      r.timer_arm      = 1'b1;
      r.timer_interval = span[31:0];
    end
    r.session_state = sess_state;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_server = 1'b0;
      hs_ticks    = 16'd1000;
      ka_ticks    = 32'd10000;
      retry_limit = 4'd5;
      sess_state  = CODE_IDLE;
      retries     = '0;
      expected_q.delete();
      pending_o   = 0;
    end else begin
      // score the result side first so a beat never meets its own event
      if (out_valid_i && out_ready_i) begin
        results_o = results_o + 1;
        if (expected_q.size() == 0) begin
          errors_o = errors_o + 1;
          if (errors_o <= MAX_REPORTS)
            $display("%0t: result beat with no event waiting, state %0d", $realtime,
                     out_data_i.session_state);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.session_state  !== want.session_state  ||
              out_data_i.send_valid     !== want.send_valid     ||
              out_data_i.send_msg       !== want.send_msg       ||
              out_data_i.timer_arm      !== want.timer_arm      ||
              out_data_i.timer_interval !== want.timer_interval ||
              out_data_i.timer_cancel   !== want.timer_cancel   ||
              out_data_i.session_closed !== want.session_closed) begin
            errors_o = errors_o + 1;
            if (errors_o <= MAX_REPORTS) begin
              $display("%0t: result %0d expected/got: state %0d/%0d send %b,%0d/%b,%0d",
                       $realtime, results_o, want.session_state, out_data_i.session_state,
                       want.send_valid, want.send_msg, out_data_i.send_valid,
                       out_data_i.send_msg);
              $display("    arm %b,%0d/%b,%0d cancel %b/%b closed %b/%b",
                       want.timer_arm, want.timer_interval,
                       out_data_i.timer_arm, out_data_i.timer_interval, want.timer_cancel,
                       out_data_i.timer_cancel, want.session_closed,
                       out_data_i.session_closed);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SERVER_ROLE:     role_server = cfg_data_i[0];
          REG_HANDSHAKE_TICKS: hs_ticks    = cfg_data_i[15:0];
          REG_KEEPALIVE_TICKS: ka_ticks    = cfg_data_i;
          REG_MAX_RETRIES:     retry_limit = cfg_data_i[3:0];
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        events_o = events_o + 1;
        expected_q.push_back(advance_session(in_data_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== tb/tb_session_handshake_fsm.sv =====
// Testbench top for the session handshake state machine: stimulus, settings and verdict.
module tb_session_handshake_fsm;
  import shs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before the run is declared hung
  localparam int HOLD_OFF_CYCLES = 60;    // long receiver stall, well past the block's depth
  localparam int HOLD_FIRST      = 300;   // event count that triggers the first stall
  localparam int HOLD_SPACING    = 400;
  localparam int RANDOM_EVENTS   = 1000;
  localparam int PHASES          = 8;
  localparam int SETTLE_CYCLES   = 8;     // a few times the block's latency

  // Flag patterns, ordered {addr_ok, crypt_ok, send_ok, challenge_match}.
  localparam logic [3:0] FL_ALL      = 4'b1111;
  localparam logic [3:0] FL_NO_ADDR  = 4'b0111;
  localparam logic [3:0] FL_NO_CRYPT = 4'b1011;
  localparam logic [3:0] FL_NO_SEND  = 4'b1101;
  localparam logic [3:0] FL_NO_MATCH = 4'b1110;

  // Any type above the reset message is dropped by the block.
  localparam logic [3:0] MSG_UNKNOWN = 4'hF;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_SERVER_ROLE;
  logic [31:0] cfg_data  = '0;

  int errors, pending, events, results;

  cfg_t settings;          // what the block was last told; shapes the sequences
  int   burst_left = 0;
  int   offered    = 0;
  int   loads      = 0;
  int   holds      = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  session_handshake_fsm dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  session_checker u_session_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .events_o    (events),
    .results_o   (results)
  );

  // ---------------------------------------------------------------------------
  // Event construction
  // ---------------------------------------------------------------------------

  function automatic in_item_t build_event(logic [1:0] cmd, logic [3:0] msg, logic [3:0] flags);
    in_item_t ev;
    ev.command  = cmd;
    ev.msg_type = msg;
    {ev.addr_ok, ev.crypt_ok, ev.send_ok, ev.challenge_match} = flags;
    return ev;
  endfunction

  // Lean toward success so sessions get past the handshake, but let every
  // outcome flag fail often enough to walk the failure paths.
  function automatic logic [3:0] biased_flags();
    logic [3:0] f;
    f[3] = $urandom_range(0, 99) < 92;
    f[2] = $urandom_range(0, 99) < 90;
    f[1] = $urandom_range(0, 99) < 88;
    f[0] = $urandom_range(0, 99) < 88;
    return f;
  endfunction

  function automatic in_item_t packet_event(logic [3:0] msg);
    return build_event(CMD_PACKET, msg, biased_flags());
  endfunction

  // The type field means nothing outside packets; randomize it anyway.
  function automatic in_item_t control_event(logic [1:0] cmd);
    return build_event(cmd, 4'($urandom_range(0, 15)), biased_flags());
  endfunction

  function automatic cfg_t pick_settings(logic server);
    cfg_t c;
    c.server_role = server;
    case ($urandom_range(0, 3))
      0:       c.handshake_ticks = 16'd1;
      1:       c.handshake_ticks = 16'hFFFF;
      default: c.handshake_ticks = 16'($urandom_range(1, 5000));
    endcase
    case ($urandom_range(0, 3))
      0:       c.keepalive_ticks = 32'd1;
      1:       c.keepalive_ticks = 32'hFFFF_FFFF;
      default: c.keepalive_ticks = $urandom | 32'd1;
    endcase
    case ($urandom_range(0, 3))
      0:       c.max_retries = 4'd0;
      1:       c.max_retries = 4'd15;
      default: c.max_retries = 4'($urandom_range(0, 15));
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers: change inputs at the falling edge, sample at the rising edge
  // ---------------------------------------------------------------------------

  // Offer one beat. The sender runs in bursts; between bursts drop valid for a
  // random gap before raising it again, so valid is never lowered and raised in
  // the same step. Valid stays high across back-to-back beats of a burst.
  task automatic offer(input in_item_t ev);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    offered++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Write one register; leave valid high so the next write can follow directly.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Load a full setting. Call only with the block drained.
  task automatic load_settings(input cfg_t c);
    settings = c;
    write_reg(REG_SERVER_ROLE, {31'd0, c.server_role});
    write_reg(REG_HANDSHAKE_TICKS, {16'd0, c.handshake_ticks});
    write_reg(REG_KEEPALIVE_TICKS, c.keepalive_ticks);
    write_reg(REG_MAX_RETRIES, {28'd0, c.max_retries});
    cfg_valid <= 1'b0;
    loads++;
  endtask

  // ---------------------------------------------------------------------------
  // Session sequences
  // ---------------------------------------------------------------------------

  // Traffic once a session should be up: keepalives, data, IP config or reset
  // packets, timer ticks, sometimes a retry-exhausting timer run, or a socket error.
  task automatic connected_traffic(input logic server);
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 5))
        0:       offer(packet_event(MSG_KA));
        1:       offer(packet_event(MSG_DATA));
        2:       offer(packet_event(server ? MSG_RST : MSG_IPCONF));
        default: offer(control_event(CMD_TIMER));
      endcase
    end
    if ($urandom_range(0, 3) == 0)
      repeat (int'(settings.max_retries) + 2) offer(control_event(CMD_TIMER));
    if ($urandom_range(0, 5) == 0) offer(control_event(CMD_ERROR));
  endtask

  task automatic client_session();
    offer(control_event(CMD_START));
    repeat ($urandom_range(0, 2)) offer(control_event(CMD_TIMER));
    offer(packet_event(MSG_CHALLENGE));
    if ($urandom_range(0, 4) == 0) begin
      offer(packet_event(MSG_DENY));
      offer(packet_event(MSG_CHALLENGE));
    end
    offer(packet_event(MSG_AUTH_OK));
    connected_traffic(1'b0);
  endtask

  task automatic server_session();
    offer(control_event(CMD_START));
    offer(packet_event(MSG_LOGIN));
    if ($urandom_range(0, 5) == 0) offer(packet_event(MSG_RST));
    offer(packet_event(MSG_RESPONSE));
    connected_traffic(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus long hold-offs that back the block up
  // ---------------------------------------------------------------------------

  initial begin : receiver
    int mode;
    int mode_left;
    int cyc;
    int next_hold;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    next_hold = HOLD_FIRST;
    forever begin
      @(negedge clk);
      cyc++;
      if (events >= next_hold) begin
        // Hold ready low while the sender keeps pushing; the block fills
        // and must stall its input side.
        out_ready <= 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        next_hold += HOLD_SPACING;
        holds++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;                         // no stalls at all
          1:       out_ready <= $urandom_range(0, 9) < 7;     // light stalls
          2:       out_ready <= $urandom_range(0, 9) < 2;     // heavy stalls
          default: out_ready <= (cyc % 3) == 0;               // fixed rhythm
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if no beat moves on any channel for too long
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and verdict
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    cfg_t c;
    int   quota;

    // Hold reset, then release it away from the rising edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset values: client role, 1000 handshake ticks, 10000 keepalive, 5 retries.
    settings.server_role     = 1'b0;
    settings.handshake_ticks = 16'd1000;
    settings.keepalive_ticks = 32'd10000;
    settings.max_retries     = 4'd5;

    // Directed client walk under the reset settings.
    offer(build_event(CMD_START, MSG_RST, FL_NO_SEND));        // login fails, stay idle
    offer(build_event(CMD_START, MSG_LOGIN, FL_ALL));          // login sent, arm
    offer(build_event(CMD_TIMER, MSG_LOGIN, FL_ALL));          // retry, interval doubles
    offer(build_event(CMD_PACKET, MSG_CHALLENGE, FL_NO_ADDR)); // wrong source, dropped
    offer(build_event(CMD_PACKET, MSG_UNKNOWN, FL_ALL));       // unknown type, dropped
    offer(build_event(CMD_PACKET, MSG_CHALLENGE, FL_ALL));     // response sent
    offer(build_event(CMD_PACKET, MSG_DENY, FL_ALL));          // denied, log in again
    offer(build_event(CMD_PACKET, MSG_CHALLENGE, FL_NO_CRYPT));// encryption short
    offer(build_event(CMD_PACKET, MSG_CHALLENGE, FL_ALL));
    offer(build_event(CMD_PACKET, MSG_AUTH_OK, FL_ALL));       // connected, keepalive timer
    offer(build_event(CMD_PACKET, MSG_KA, FL_ALL));
    offer(build_event(CMD_PACKET, MSG_IPCONF, FL_ALL));
    offer(build_event(CMD_PACKET, MSG_LOGIN, FL_ALL));         // no action here, dropped
    offer(build_event(CMD_TIMER, MSG_DATA, FL_NO_SEND));       // keepalive send fails
    offer(build_event(CMD_ERROR, MSG_KA, FL_ALL));             // client falls back to idle

    // Directed server walk at the far end of the tick ranges.
    drain();
    c.server_role     = 1'b1;
    c.handshake_ticks = 16'hFFFF;
    c.keepalive_ticks = 32'hFFFF_FFFF;
    c.max_retries     = 4'd15;
    load_settings(c);
    offer(build_event(CMD_START, MSG_LOGIN, FL_ALL));          // listen
    offer(build_event(CMD_PACKET, MSG_LOGIN, FL_NO_ADDR));     // listen ignores the address
    offer(build_event(CMD_PACKET, MSG_RESPONSE, FL_NO_MATCH)); // bad response, rearm
    offer(build_event(CMD_PACKET, MSG_RST, FL_ALL));           // go stale
    offer(build_event(CMD_TIMER, MSG_LOGIN, FL_ALL));          // stale session freed
    offer(build_event(CMD_PACKET, MSG_LOGIN, FL_NO_SEND));     // challenge send fails
    offer(build_event(CMD_ERROR, MSG_LOGIN, FL_ALL));          // server stays stale
    offer(build_event(CMD_START, MSG_LOGIN, FL_ALL));
    offer(build_event(CMD_PACKET, MSG_LOGIN, FL_ALL));
    offer(build_event(CMD_PACKET, MSG_RESPONSE, FL_ALL));      // server connected
    offer(build_event(CMD_TIMER, MSG_LOGIN, FL_ALL));          // keepalive out

    // Random phases: mostly well-formed sessions with random outcomes, some
    // noise. Force extreme settings in the first two phases.
    for (int p = 0; p < PHASES; p++) begin
      c = pick_settings(p[0]);
      if (p < 2) begin
        c.handshake_ticks = p[0] ? 16'hFFFF : 16'd1;
        c.keepalive_ticks = 32'd1;
        c.max_retries     = 4'd0;
      end
      drain();
      load_settings(c);
      quota = offered + RANDOM_EVENTS / PHASES;
      while (offered < quota) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            repeat ($urandom_range(1, 4))
              offer(build_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                4'($urandom_range(0, 15))));
          end
          default: begin
            if (settings.server_role) server_session();
            else                      client_session();
          end
        endcase
      end
    end

    // Let the last results out, then give the block a few more cycles.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d events to %0d result beats over %0d register loads, both roles.",
             events, results, loads);
    $display("Tick and retry limits hit both extremes; %0d long receiver stalls.", holds);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
